// ----- design/madt_pkg.sv -----
// ----------------------------------------------------------------------------
// MADT parser package
// Shared constants, record kinds and the record structures that pass between
// the parse core, the result queue and the top level.
// ----------------------------------------------------------------------------
package madt_pkg;

    // Fixed table layout.
    localparam int unsigned HEADER_BYTES       = 44;
    localparam int unsigned ENTRY_BUFFER_BYTES = 12;
    localparam int unsigned LEN_FIELD_POS      = 4;
    localparam int unsigned REV_FIELD_POS      = 8;
    localparam int unsigned LAPIC_FIELD_POS    = 36;
    localparam int unsigned FLAGS_FIELD_POS    = 40;

    // Minimum entry lengths for the decoded entry types.
    localparam logic [7:0] MIN_LEN_LAPIC      = 8'd8;
    localparam logic [7:0] MIN_LEN_IOAPIC     = 8'd12;
    localparam logic [7:0] MIN_LEN_OVERRIDE   = 8'd10;
    localparam logic [7:0] MIN_LEN_NMI_SRC    = 8'd8;
    localparam logic [7:0] MIN_LEN_LAPIC_NMI  = 8'd6;
    localparam logic [7:0] MIN_LEN_ADDR_OVR   = 8'd12;
    localparam logic [7:0] MIN_ENTRY_LEN      = 8'd2;

    // Entry type codes.
    localparam logic [7:0] TYPE_LAPIC     = 8'd0;
    localparam logic [7:0] TYPE_IOAPIC    = 8'd1;
    localparam logic [7:0] TYPE_OVERRIDE  = 8'd2;
    localparam logic [7:0] TYPE_NMI_SRC   = 8'd3;
    localparam logic [7:0] TYPE_LAPIC_NMI = 8'd4;
    localparam logic [7:0] TYPE_ADDR_OVR  = 8'd5;

    // Result queue depth (a power of two).
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        KIND_HEADER    = 4'd0,
        KIND_LAPIC     = 4'd1,
        KIND_IOAPIC    = 4'd2,
        KIND_OVERRIDE  = 4'd3,
        KIND_NMI_SRC   = 4'd4,
        KIND_LAPIC_NMI = 4'd5,
        KIND_ADDR_OVR  = 4'd6,
        KIND_UNKNOWN   = 4'd7,
        KIND_DONE      = 4'd8,
        KIND_TOO_SMALL = 4'd9,
        KIND_SHORT     = 4'd10,
        KIND_OVERRUN   = 4'd11
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] entry_number;
        logic [31:0] entry_offset;
        logic [7:0]  entry_type;
        logic [7:0]  entry_length;
        logic [7:0]  id_first;
        logic [7:0]  id_second;
        logic [31:0] flag_bits;
        logic [63:0] value_wide;
        logic [31:0] value_second;
        logic        end_of_run;
    } record_t;

    // Up to two records produced by one table byte.
    typedef struct packed {
        logic [1:0] count;
        record_t    first;
        record_t    second;
    } push_t;

endpackage

// ----- design/madt_rec_fifo.sv -----
// ----------------------------------------------------------------------------
// MADT result queue
// Small queue that takes up to two records per cycle from the parse core and
// hands them out one per transfer on the output channel.
// ----------------------------------------------------------------------------
module madt_rec_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  madt_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output madt_pkg::record_t head
);

    localparam int unsigned DEPTH = madt_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    madt_pkg::record_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          pop;

    // Room for a full pair of records is needed before the core may proceed.
    assign room      = (count_reg <= CW'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage; the second record of a pair lands in the next slot.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

endmodule

// ----- design/madt_parse_core.sv -----
// ----------------------------------------------------------------------------
// MADT parse core
// Input register, table state and the single-pass record logic. Each
// registered byte is consumed as soon as the result queue has room.
// ----------------------------------------------------------------------------
module madt_parse_core #(
    parameter int unsigned BUF_BYTES = madt_pkg::ENTRY_BUFFER_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      byte_value,
    input  logic            table_start,
    input  logic            room,
    output madt_pkg::push_t push
);

    localparam int unsigned IW = $clog2(BUF_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_ENTRY  = 2'd2
    } phase_t;

    // Input register.
    logic       in_full_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       consume;

    // Table state.
    phase_t      phase_reg,  phase_next, phase_eff;
    logic [31:0] pos_reg,    pos_next,   pos_eff;
    logic [31:0] tsize_reg,  tsize_next, tsize_eff;
    logic [7:0]  rev_reg,    rev_next,   rev_eff;
    logic [31:0] lapic_reg,  lapic_next, lapic_eff;
    logic [31:0] flags_reg,  flags_next, flags_eff;
    logic [31:0] estart_reg, estart_next, estart_eff;
    logic [31:0] ecount_reg, ecount_next, ecount_eff;

    // Entry byte buffer; never cleared, decoding only reads written bytes.
    logic [7:0] ebuf [BUF_BYTES];

    logic [BUF_BYTES-1:0][7:0] view;
    logic [31:0]       rel;
    logic              at_len;
    logic              at_last;
    logic [32:0]       entry_end;
    logic [33:0]       entry_end_gap;
    logic              buf_write;
    madt_pkg::record_t rec_a;
    madt_pkg::record_t rec_b;
    logic [1:0]        n_rec;

    // Done record: entries decoded so far and where parsing stopped.
    function automatic madt_pkg::record_t make_done(
        input logic [31:0] count,
        input logic [31:0] offset
    );
        madt_pkg::record_t r;
        r              = '0;
        r.kind         = madt_pkg::KIND_DONE;
        r.entry_number = count;
        r.entry_offset = offset;
        r.end_of_run   = 1'b1;
        return r;
    endfunction

    // Decoded entry record from the entry bytes seen so far.
    function automatic madt_pkg::record_t make_entry(
        input logic [BUF_BYTES-1:0][7:0] v,
        input logic [31:0]               count,
        input logic [31:0]               offset,
        input logic [7:0]                etype,
        input logic [7:0]                elen
    );
        madt_pkg::record_t r;
        r              = '0;
        r.kind         = madt_pkg::KIND_UNKNOWN;
        r.entry_number = count;
        r.entry_offset = offset;
        r.entry_type   = etype;
        r.entry_length = elen;
        if (etype == madt_pkg::TYPE_LAPIC && elen >= madt_pkg::MIN_LEN_LAPIC)
        begin
            r.kind      = madt_pkg::KIND_LAPIC;
            r.id_first  = v[2];
            r.id_second = v[3];
            r.flag_bits = {v[7], v[6], v[5], v[4]};
        end
        else if (etype == madt_pkg::TYPE_IOAPIC && elen >= madt_pkg::MIN_LEN_IOAPIC)
        begin
            r.kind         = madt_pkg::KIND_IOAPIC;
            r.id_first     = v[2];
            r.value_wide   = {32'd0, v[7], v[6], v[5], v[4]};
            r.value_second = {v[11], v[10], v[9], v[8]};
        end
        else if (etype == madt_pkg::TYPE_OVERRIDE && elen >= madt_pkg::MIN_LEN_OVERRIDE)
        begin
            r.kind       = madt_pkg::KIND_OVERRIDE;
            r.id_first   = v[2];
            r.id_second  = v[3];
            r.value_wide = {32'd0, v[7], v[6], v[5], v[4]};
            r.flag_bits  = {16'd0, v[9], v[8]};
        end
        else if (etype == madt_pkg::TYPE_NMI_SRC && elen >= madt_pkg::MIN_LEN_NMI_SRC)
        begin
            r.kind       = madt_pkg::KIND_NMI_SRC;
            r.flag_bits  = {16'd0, v[3], v[2]};
            r.value_wide = {32'd0, v[7], v[6], v[5], v[4]};
        end
        else if (etype == madt_pkg::TYPE_LAPIC_NMI && elen >= madt_pkg::MIN_LEN_LAPIC_NMI)
        begin
            r.kind      = madt_pkg::KIND_LAPIC_NMI;
            r.id_first  = v[2];
            r.flag_bits = {16'd0, v[4], v[3]};
            r.id_second = v[5];
        end
        else if (etype == madt_pkg::TYPE_ADDR_OVR && elen >= madt_pkg::MIN_LEN_ADDR_OVR)
        begin
            r.kind       = madt_pkg::KIND_ADDR_OVR;
            r.value_wide = {v[11], v[10], v[9], v[8], v[7], v[6], v[5], v[4]};
        end
        return r;
    endfunction

    // Input handshake: the register refills in the cycle it is consumed.
    assign consume  = in_full_reg && room;
    assign in_ready = !in_full_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_full_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg  <= byte_value;
            in_start_reg <= table_start;
        end
    end

    // State seen by this byte: a table start restarts everything.
    always_comb
    begin
        phase_eff  = phase_reg;
        pos_eff    = pos_reg;
        tsize_eff  = tsize_reg;
        rev_eff    = rev_reg;
        lapic_eff  = lapic_reg;
        flags_eff  = flags_reg;
        estart_eff = estart_reg;
        ecount_eff = ecount_reg;
        if (in_start_reg)
        begin
            phase_eff  = PH_HEADER;
            pos_eff    = '0;
            tsize_eff  = '0;
            rev_eff    = '0;
            lapic_eff  = '0;
            flags_eff  = '0;
            estart_eff = '0;
            ecount_eff = '0;
        end
    end

    // Entry view: buffered bytes with the current byte laid over its slot.
    always_comb
    begin
        rel = pos_eff - estart_eff;
        for (int i = 0; i < BUF_BYTES; i++)
        begin
            view[i] = (rel == 32'(i)) ? in_byte_reg : ebuf[i];
        end
        at_len        = (rel == 32'd1);
        at_last       = (rel >= 32'd2) && (rel == ({24'd0, view[1]} - 32'd1));
        entry_end     = {1'b0, estart_eff} + {25'd0, view[1]};
        entry_end_gap = {1'b0, entry_end} + 34'd2;
        buf_write     = (phase_eff == PH_ENTRY) && (rel < 32'(BUF_BYTES));
    end

    // Record logic and next state.
    always_comb
    begin
        phase_next  = phase_eff;
        pos_next    = pos_eff;
        tsize_next  = tsize_eff;
        rev_next    = rev_eff;
        lapic_next  = lapic_eff;
        flags_next  = flags_eff;
        estart_next = estart_eff;
        ecount_next = ecount_eff;
        rec_a       = '0;
        rec_b       = '0;
        n_rec       = 2'd0;

        case (phase_eff)
            PH_HEADER:
            begin
                // Gather the header fields byte by byte.
                for (int k = 0; k < 4; k++)
                begin
                    if (pos_eff == 32'(madt_pkg::LEN_FIELD_POS + k))
                    begin
                        tsize_next[8*k +: 8] = in_byte_reg;
                    end
                    if (pos_eff == 32'(madt_pkg::LAPIC_FIELD_POS + k))
                    begin
                        lapic_next[8*k +: 8] = in_byte_reg;
                    end
                    if (pos_eff == 32'(madt_pkg::FLAGS_FIELD_POS + k))
                    begin
                        flags_next[8*k +: 8] = in_byte_reg;
                    end
                end
                if (pos_eff == 32'(madt_pkg::REV_FIELD_POS))
                begin
                    rev_next = in_byte_reg;
                end
                pos_next = pos_eff + 32'd1;

                if (pos_eff == 32'(madt_pkg::LEN_FIELD_POS + 3)
                    && tsize_next < 32'(madt_pkg::HEADER_BYTES))
                begin
                    // Table too small to hold a header: stop without done.
                    rec_a.kind         = madt_pkg::KIND_TOO_SMALL;
                    rec_a.entry_offset = tsize_next;
                    rec_a.end_of_run   = 1'b1;
                    n_rec              = 2'd1;
                    phase_next         = PH_IDLE;
                end
                else if (pos_eff == 32'(madt_pkg::HEADER_BYTES - 1))
                begin
                    rec_a.kind         = madt_pkg::KIND_HEADER;
                    rec_a.entry_offset = tsize_next;
                    rec_a.id_first     = rev_next;
                    rec_a.flag_bits    = flags_next;
                    rec_a.value_wide   = {32'd0, lapic_next};
                    rec_a.end_of_run   = 1'b1;
                    n_rec              = 2'd1;
                    estart_next        = 32'(madt_pkg::HEADER_BYTES);
                    phase_next         = PH_ENTRY;
                    // Fewer than two bytes left after the header.
                    if (tsize_next < 32'(madt_pkg::HEADER_BYTES + 2))
                    begin
                        rec_a.end_of_run = 1'b0;
                        rec_b            = make_done(ecount_eff, estart_next);
                        n_rec            = 2'd2;
                        phase_next       = PH_IDLE;
                    end
                end
            end

            PH_ENTRY:
            begin
                pos_next = pos_eff + 32'd1;
                if (at_len && in_byte_reg < madt_pkg::MIN_ENTRY_LEN)
                begin
                    // Length byte too small to make progress.
                    rec_a.kind         = madt_pkg::KIND_SHORT;
                    rec_a.entry_number = ecount_eff;
                    rec_a.entry_offset = estart_eff;
                    rec_a.entry_type   = view[0];
                    rec_a.entry_length = in_byte_reg;
                    rec_b              = make_done(ecount_eff, estart_eff);
                    n_rec              = 2'd2;
                    phase_next         = PH_IDLE;
                end
                else if (at_len && entry_end > {1'b0, tsize_eff})
                begin
                    // Entry reaches past the end of the table.
                    rec_a.kind         = madt_pkg::KIND_OVERRUN;
                    rec_a.entry_number = ecount_eff;
                    rec_a.entry_offset = estart_eff;
                    rec_a.entry_type   = view[0];
                    rec_a.entry_length = in_byte_reg;
                    rec_b              = make_done(ecount_eff, estart_eff);
                    n_rec              = 2'd2;
                    phase_next         = PH_IDLE;
                end
                else if ((at_len && in_byte_reg == madt_pkg::MIN_ENTRY_LEN) || at_last)
                begin
                    // Last entry byte: decode, then next entry or done.
                    rec_a       = make_entry(view, ecount_eff, estart_eff, view[0], view[1]);
                    rec_a.end_of_run = 1'b1;
                    n_rec       = 2'd1;
                    ecount_next = ecount_eff + 32'd1;
                    estart_next = entry_end[31:0];
                    if (entry_end_gap > {2'd0, tsize_eff})
                    begin
                        rec_a.end_of_run = 1'b0;
                        rec_b            = make_done(ecount_next, estart_next);
                        n_rec            = 2'd2;
                        phase_next       = PH_IDLE;
                    end
                end
            end

            default:
            begin
            end
        endcase

        push.count  = consume ? n_rec : 2'd0;
        push.first  = rec_a;
        push.second = rec_b;
    end

    // Table state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            tsize_reg  <= '0;
            rev_reg    <= '0;
            lapic_reg  <= '0;
            flags_reg  <= '0;
            estart_reg <= '0;
            ecount_reg <= '0;
        end
        else if (consume)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tsize_reg  <= tsize_next;
            rev_reg    <= rev_next;
            lapic_reg  <= lapic_next;
            flags_reg  <= flags_next;
            estart_reg <= estart_next;
            ecount_reg <= ecount_next;
        end
    end

    // Entry byte buffer: only the first bytes of each entry are kept.
    always_ff @(posedge clk)
    begin
        if (consume && buf_write)
        begin
            ebuf[rel[IW-1:0]] <= in_byte_reg;
        end
    end

endmodule

// ----- design/madt_entry_parser.sv -----
// ----------------------------------------------------------------------------
// MADT entry parser
// Streaming parser for an interrupt controller description table.
// ----------------------------------------------------------------------------
// The input channel carries one table byte per transfer, in table order, with
// table_start set on the first byte of each table; a start restarts the parse
// in any phase. The output channel carries one decoded record per transfer:
// the header, each entry, and the closing done or error record. A byte causes
// at most two records, and end_of_run marks the last one.
// A byte is registered on transfer and processed once the result queue has
// room; the records it causes are written into the queue and offered from
// there. One byte is taken every cycle while the receiver keeps up; the rate
// is set by the result queue, which must have room for two records before a
// byte is processed and drains one record per cycle.
// When the receiver stalls, records wait in the four-entry queue. Once fewer
// than two slots are free the registered byte is held, and the input stops
// accepting as soon as that register is full. Reset empties the queue and the
// input register and returns the parser to idle, where bytes without
// table_start are dropped.
// ----------------------------------------------------------------------------
module madt_entry_parser #(
    parameter int unsigned ENTRY_BUFFER_BYTES = madt_pkg::ENTRY_BUFFER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        table_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  record_kind,
    output logic [31:0] entry_number,
    output logic [31:0] entry_offset,
    output logic [7:0]  entry_type,
    output logic [7:0]  entry_length,
    output logic [7:0]  id_first,
    output logic [7:0]  id_second,
    output logic [31:0] flag_bits,
    output logic [63:0] value_wide,
    output logic [31:0] value_second,
    output logic        end_of_run
);

    madt_pkg::push_t   push;
    madt_pkg::record_t head;
    logic              room;

    // Byte parsing.
    madt_parse_core #(
        .BUF_BYTES(ENTRY_BUFFER_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .table_start(table_start),
        .room       (room),
        .push       (push)
    );

    // Record queue towards the output channel.
    madt_rec_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .head     (head)
    );

    // Unpack the head record onto the output fields.
    assign record_kind  = head.kind;
    assign entry_number = head.entry_number;
    assign entry_offset = head.entry_offset;
    assign entry_type   = head.entry_type;
    assign entry_length = head.entry_length;
    assign id_first     = head.id_first;
    assign id_second    = head.id_second;
    assign flag_bits    = head.flag_bits;
    assign value_wide   = head.value_wide;
    assign value_second = head.value_second;
    assign end_of_run   = head.end_of_run;

endmodule

// ----- design/madt_checker.sv -----
// ----------------------------------------------------------------------------
// MADT parser checker
// Port-level checks on the output channel of the parser.
// ----------------------------------------------------------------------------
module madt_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  record_kind,
    input logic [31:0] entry_number,
    input logic [31:0] entry_offset,
    input logic        end_of_run
);

    // A stalled record stays offered; kind, offset and end_of_run hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(record_kind)
            && $stable(entry_offset) && $stable(end_of_run))
    else $error("output record changed while stalled");

    // Only defined record kinds leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> record_kind <= madt_pkg::KIND_OVERRUN)
    else $error("undefined record kind");

    // A too-small table ends its run alone, before any entry is counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == madt_pkg::KIND_TOO_SMALL
            |-> end_of_run && entry_number == 32'd0)
    else $error("too-small record malformed");

    // Entry errors are always followed by a done record from the same byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (record_kind == madt_pkg::KIND_SHORT
            || record_kind == madt_pkg::KIND_OVERRUN) |-> !end_of_run)
    else $error("entry error closed its run");

endmodule

bind madt_entry_parser madt_port_checks u_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .record_kind (record_kind),
    .entry_number(entry_number),
    .entry_offset(entry_offset),
    .end_of_run  (end_of_run)
);
